### sv/dcr_pkg.sv
// ============================================================================
// dcr_pkg: shared types and constants for the diverging colormap core
// Holds field widths, register indexes, color constants, the sequencer
// state type and the sample magnitude helper.
// ============================================================================
package dcr_pkg;

    // Sample and store geometry
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_PIXELS  = 4096;
    localparam int ADDR_BITS   = $clog2(MAX_PIXELS);
    localparam int INDEX_BITS  = ADDR_BITS + 1;

    // Register and field widths
    localparam int SIDE_BITS   = 7;
    localparam int SCALE_BITS  = 5;
    localparam int CFG_BITS    = 7;
    localparam int COL_BITS    = 6;
    localparam int ROW_BITS    = 10;
    localparam int SUB_BITS    = 4;
    localparam int DISP_BITS   = 11;
    localparam int COLOR_BITS  = 16;
    localparam int QUOT_BITS   = 8;
    localparam int NUM_BITS    = SAMPLE_BITS + QUOT_BITS - 1;
    localparam int S_DATA_BITS = 24;
    localparam int M_DATA_BITS = 64;

    // Register clamp limits
    localparam logic [SIDE_BITS-1:0]  SIDE_MIN  = 7'd1;
    localparam logic [SIDE_BITS-1:0]  SIDE_MAX  = 7'd64;
    localparam logic [SCALE_BITS-1:0] SCALE_MIN = 5'd1;
    localparam logic [SCALE_BITS-1:0] SCALE_MAX = 5'd16;
    localparam logic [SIDE_BITS-1:0]  SIDE_RESET  = 7'd32;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 5'd4;

    // Register indexes
    localparam logic CFG_IMAGE_SIDE = 1'b0;
    localparam logic CFG_UPSCALE    = 1'b1;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Color constants
    localparam logic [QUOT_BITS-1:0]  FULL_SCALE = 8'd255;
    localparam logic [QUOT_BITS-1:0]  RED_MASK   = 8'hF8;
    localparam logic [COLOR_BITS-1:0] BLACK      = 16'h0000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ADDR,
        S_READ,
        S_MAG,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    // Absolute value of a two's complement sample; the most negative value
    // maps to its true magnitude, which still fits the unsigned width.
    function automatic logic [SAMPLE_BITS-1:0] f_magnitude(
        input logic [SAMPLE_BITS-1:0] raw
    );
        logic [SAMPLE_BITS-1:0] mag;
        mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
        return mag;
    endfunction

endpackage

### sv/diverging_colormap_rgb565_upscale_core.sv
// ============================================================================
// diverging_colormap_rgb565_upscale_core
// Stores signed samples with a valid flag, tracks the peak magnitude and
// renders each source pixel as a run of replicated RGB565 display pixels.
// ============================================================================
//
//  Channel   Dir  Handshake               Content
//  -------   ---  ---------               -------
//  s stream  in   i_s_tvalid/o_s_tready   sample, cmd and valid flag, tlast
//  m stream  out  o_m_tvalid/i_m_tready   color, position, peak, run/frame ends
//  cfg       in   i_cfg_we                image_side (0), upscale (1)
//
//  A load word is captured, then the peak is updated.
//  A render word passes through the accepting cycle, address multiply,
//  store read, magnitude, numerator and eight steps of the restoring
//  divider, then emits one display pixel per cycle unless the output
//  stalls. The divider loop and the emit loop dominate.
//  Reset (synchronous, active low) clears the control state; the sample store
//  is not cleared and needs no clearing pass.
//  A stall on the output holds the emit loop; the last word of a run waits in
//  the output register while the next input word is accepted.
// ============================================================================
module diverging_colormap_rgb565_upscale_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dcr_pkg::S_DATA_BITS-1:0]     i_s_tdata,   // [23:0] sample_value
    input  logic                                i_s_tlast,   // last_sample
    input  logic [1:0]                          i_s_tuser,   // [0] cmd, [1] sample_valid
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [dcr_pkg::M_DATA_BITS-1:0]     o_m_tdata,   // [15:0] pixel_colour,
                                                             // [25:16] display_row,
                                                             // [35:26] display_col,
                                                             // [59:36] peak_magnitude,
                                                             // [63:60] zero
    output logic                                o_m_tlast,   // last_of_run
    output logic [0:0]                          o_m_tuser,   // [0] last_of_frame
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dcr_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import dcr_pkg::*;

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    t_state r_state, n_state;

    logic [SIDE_BITS-1:0]    r_image_side;
    logic [SCALE_BITS-1:0]   r_upscale;
    logic [SIDE_BITS-1:0]    w_side;
    logic [SCALE_BITS-1:0]   w_scale;
    logic [DISP_BITS-1:0]    w_disp;

    logic [INDEX_BITS-1:0]   r_load_index;
    logic [SAMPLE_BITS-1:0]  r_peak;
    logic [COL_BITS-1:0]     r_render_col;
    logic [ROW_BITS-1:0]     r_render_row;
    logic [COL_BITS-1:0]     r_src_row;
    logic [SUB_BITS-1:0]     r_sub;

    // Sample store: sample in the low bits, valid flag on top
    logic [SAMPLE_BITS:0]    r_store [MAX_PIXELS];
    logic [SAMPLE_BITS:0]    r_rd;
    logic [ADDR_BITS-1:0]    r_addr;

    // Load word capture
    logic [SAMPLE_BITS-1:0]  r_ld_raw;
    logic                    r_ld_ok;
    logic                    r_ld_do;
    logic                    r_ld_first;

    // Render item working registers
    logic [COL_BITS-1:0]     r_cur_col;
    logic [ROW_BITS-1:0]     r_cur_row;
    logic [COL_BITS-1:0]     r_cur_src;
    logic                    r_frame_end;
    logic [ROW_BITS-1:0]     r_col_base;
    logic [SAMPLE_BITS-1:0]  r_mag;
    logic                    r_neg;
    logic                    r_ok;
    logic                    r_black;
    logic                    r_sat;
    logic [SAMPLE_BITS-1:0]  r_rem;
    logic [QUOT_BITS-1:0]    r_num_lo;
    logic [QUOT_BITS-1:0]    r_quot;
    logic [2:0]              r_step;
    logic [SUB_BITS-1:0]     r_k;

    // Output register
    logic                    r_out_valid;
    logic [COLOR_BITS-1:0]   r_out_color;
    logic [ROW_BITS-1:0]     r_out_row;
    logic [ROW_BITS-1:0]     r_out_col;
    logic [SAMPLE_BITS-1:0]  r_out_peak;
    logic                    r_out_last;
    logic                    r_out_frame;

    // Handshake and datapath helpers
    logic                    w_accept;
    logic                    w_load;
    logic                    w_render;
    logic                    w_emit;
    logic                    w_last_k;
    logic                    w_wrap;
    logic [COL_BITS-1:0]     w_eff_col;
    logic [ROW_BITS-1:0]     w_eff_row;
    logic [COL_BITS-1:0]     w_eff_src;
    logic [SUB_BITS-1:0]     w_eff_sub;
    logic                    w_col_last;
    logic                    w_row_last;
    logic                    w_sub_last;
    logic [SAMPLE_BITS-1:0]  w_ld_mag;
    logic [SAMPLE_BITS-1:0]  w_ld_base;
    logic [NUM_BITS-1:0]     w_num;
    logic [SAMPLE_BITS:0]    w_trial;
    logic                    w_fits;
    logic [QUOT_BITS-1:0]    w_intensity;
    logic [COLOR_BITS-1:0]   w_color;
    logic [ADDR_BITS+1:0]    w_addr_full;

    // ------------------------------------------------------------------------
    // Clamped geometry
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_image_side < SIDE_MIN) begin
            w_side = SIDE_MIN;
        end else if (r_image_side > SIDE_MAX) begin
            w_side = SIDE_MAX;
        end else begin
            w_side = r_image_side;
        end
        if (r_upscale < SCALE_MIN) begin
            w_scale = SCALE_MIN;
        end else if (r_upscale > SCALE_MAX) begin
            w_scale = SCALE_MAX;
        end else begin
            w_scale = r_upscale;
        end
        w_disp = DISP_BITS'(w_side * w_scale);
    end

    // ------------------------------------------------------------------------
    // Render position at accept: wrap guard and advance flags
    // ------------------------------------------------------------------------
    always_comb begin
        w_wrap     = ({1'b0, r_render_col} >= w_side) ||
                     ({1'b0, r_render_row} >= w_disp);
        w_eff_col  = w_wrap ? '0 : r_render_col;
        w_eff_row  = w_wrap ? '0 : r_render_row;
        w_eff_src  = w_wrap ? '0 : r_src_row;
        w_eff_sub  = w_wrap ? '0 : r_sub;
        w_col_last = ({1'b0, w_eff_col} == (w_side - 1'b1));
        w_row_last = ({1'b0, w_eff_row} == (w_disp - 1'b1));
        w_sub_last = ({1'b0, w_eff_sub} == (w_scale - 1'b1));
    end

    // ------------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------------
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_load   = w_accept && (i_s_tuser[0] == CMD_LOAD);
    assign w_render = w_accept && (i_s_tuser[0] == CMD_RENDER);
    assign w_last_k = ({1'b0, r_k} == (w_scale - 1'b1));

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    n_state = S_LOAD;
                end else if (w_render) begin
                    n_state = S_ADDR;
                end
            end
            S_LOAD: n_state = S_IDLE;
            S_ADDR: n_state = S_READ;
            S_READ: n_state = S_MAG;
            S_MAG:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit && w_last_k) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        w_emit     = 1'b0;
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_EMIT: w_emit     = !r_out_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
                w_emit     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_side <= SIDE_RESET;
            r_upscale    <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIDE: r_image_side <= i_cfg_data;
                CFG_UPSCALE:    r_upscale    <= i_cfg_data[SCALE_BITS-1:0];
                default:        r_upscale    <= r_upscale;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Load index and render position
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_index <= '0;
            r_render_col <= '0;
            r_render_row <= '0;
            r_src_row    <= '0;
            r_sub        <= '0;
        end else if (i_cfg_we) begin
            r_render_col <= '0;
            r_render_row <= '0;
            r_src_row    <= '0;
            r_sub        <= '0;
        end else if (w_load) begin
            if (!r_load_index[ADDR_BITS] && (r_load_index == '0)) begin
                r_render_col <= '0;
                r_render_row <= '0;
                r_src_row    <= '0;
                r_sub        <= '0;
            end
            if (i_s_tlast) begin
                r_load_index <= '0;
            end else if (!r_load_index[ADDR_BITS]) begin
                r_load_index <= r_load_index + 1'b1;
            end
        end else if (w_render) begin
            if (!w_col_last) begin
                r_render_col <= w_eff_col + 1'b1;
                r_render_row <= w_eff_row;
                r_src_row    <= w_eff_src;
                r_sub        <= w_eff_sub;
            end else if (w_row_last) begin
                r_render_col <= '0;
                r_render_row <= '0;
                r_src_row    <= '0;
                r_sub        <= '0;
            end else begin
                r_render_col <= '0;
                r_render_row <= w_eff_row + 1'b1;
                if (w_sub_last) begin
                    r_sub     <= '0;
                    r_src_row <= w_eff_src + 1'b1;
                end else begin
                    r_sub     <= w_eff_sub + 1'b1;
                    r_src_row <= w_eff_src;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample store: one write port for loads, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load && !r_load_index[ADDR_BITS]) begin
            r_store[r_load_index[ADDR_BITS-1:0]] <=
                {i_s_tuser[1], i_s_tdata[SAMPLE_BITS-1:0]};
        end
        r_rd <= r_store[r_addr];
    end

    // ------------------------------------------------------------------------
    // Load word capture
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ld_raw   <= i_s_tdata[SAMPLE_BITS-1:0];
            r_ld_ok    <= i_s_tuser[1];
            r_ld_do    <= !r_load_index[ADDR_BITS];
            r_ld_first <= (r_load_index == '0);
        end
    end

    // ------------------------------------------------------------------------
    // Peak tracking: a frame's first load restarts the peak
    // ------------------------------------------------------------------------
    assign w_ld_mag  = f_magnitude(r_ld_raw);
    assign w_ld_base = r_ld_first ? '0 : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if ((r_state == S_LOAD) && r_ld_do) begin
            if (r_ld_ok && (w_ld_mag > w_ld_base)) begin
                r_peak <= w_ld_mag;
            end else begin
                r_peak <= w_ld_base;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Render item capture and store address
    // ------------------------------------------------------------------------
    assign w_addr_full = (ADDR_BITS+2)'(r_cur_src * w_side) + (ADDR_BITS+2)'(r_cur_col);

    always_ff @(posedge i_clk) begin
        if (w_render) begin
            r_cur_col   <= w_eff_col;
            r_cur_row   <= w_eff_row;
            r_cur_src   <= w_eff_src;
            r_frame_end <= w_col_last && w_row_last;
        end
        if (r_state == S_ADDR) begin
            r_addr     <= w_addr_full[ADDR_BITS-1:0];
            r_col_base <= ROW_BITS'(r_cur_col * w_scale);
        end
    end

    // ------------------------------------------------------------------------
    // Magnitude, numerator and restoring divider
    // ------------------------------------------------------------------------
    // The numerator mag * 255 is formed as mag * 256 - mag; it fits 31 bits.
    assign w_num   = NUM_BITS'({r_mag, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, r_mag});
    assign w_trial = {r_rem, r_num_lo[QUOT_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, r_peak});

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MAG: begin
                r_mag <= f_magnitude(r_rd[SAMPLE_BITS-1:0]);
                r_neg <= r_rd[SAMPLE_BITS-1];
                r_ok  <= r_rd[SAMPLE_BITS];
            end
            S_PREP: begin
                // Numerator is mag * 255; the quotient fits eight bits
                // whenever the magnitude stays below the peak.
                r_black  <= !r_ok || (r_peak == '0) || (r_mag == '0);
                r_sat    <= (r_mag >= r_peak);
                r_rem    <= SAMPLE_BITS'(w_num[NUM_BITS-1:QUOT_BITS]);
                r_num_lo <= w_num[QUOT_BITS-1:0];
                r_step   <= 3'd7;
                r_quot   <= '0;
            end
            S_DIV: begin
                if (w_fits) begin
                    r_rem <= SAMPLE_BITS'(w_trial - {1'b0, r_peak});
                end else begin
                    r_rem <= w_trial[SAMPLE_BITS-1:0];
                end
                r_quot   <= {r_quot[QUOT_BITS-2:0], w_fits};
                r_num_lo <= {r_num_lo[QUOT_BITS-2:0], 1'b0};
                r_step   <= r_step - 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Color: black for invalid or zero samples or a zero peak, red for positive samples, blue for negative ones
    // ------------------------------------------------------------------------
    always_comb begin
        w_intensity = r_sat ? FULL_SCALE : r_quot;
        if (r_black) begin
            w_color = BLACK;
        end else if (r_neg) begin
            w_color = COLOR_BITS'(w_intensity >> 3);
        end else begin
            w_color = {(w_intensity & RED_MASK), 8'h00};
        end
    end

    // ------------------------------------------------------------------------
    // Emit loop and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_render) begin
                r_k <= '0;
            end else if (w_emit) begin
                r_k <= r_k + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_color <= w_color;
            r_out_row   <= r_cur_row;
            r_out_col   <= r_col_base + ROW_BITS'(r_k);
            r_out_peak  <= r_peak;
            r_out_last  <= w_last_k;
            r_out_frame <= w_last_k && r_frame_end;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {4'b0000, r_out_peak, r_out_col, r_out_row, r_out_color};
    assign o_m_tlast    = r_out_last;
    assign o_m_tuser[0] = r_out_frame;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The emit counter never runs past the replication factor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_k} < w_scale))
        else $error("emit counter beyond upscale");

    // The source row and sub-row counters track the display row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            ((ROW_BITS'(r_src_row * w_scale) + ROW_BITS'(r_sub)) == r_render_row))
        else $error("source row tracking out of step");

    // The load index never exceeds the store depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_index <= INDEX_BITS'(MAX_PIXELS))
        else $error("load index beyond store depth");

    // The end-of-frame mark only comes with the end of a run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("frame end without run end");

    // A finished divide always leads straight into emitting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_step == '0)) |=> (r_state == S_EMIT))
        else $error("divider did not hand over to emit");

endmodule
